@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked at every edge outside reset
`define SABTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define SABTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SABTC_ASSERT(lbl, prop, msg)
`define SABTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/sabtc_pkg.sv @@
// constants and types of the block tag store with clock replacement
package sabtc_pkg;

  localparam int WAYS_DEF  = 4;
  localparam int SETS_DEF  = 256;

  localparam int ACT_W     = 2;
  localparam int SIDX_W    = 8;
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 30;
  localparam int ENTRY_W   = TAG_W + 1;
  localparam int OUT_WAY_W = 2;

  localparam logic [ADDR_W-1:0] ADDR_WORD_MASK = 32'hfffffffc;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ALLOC  = 2'd1,
    ACT_CLEAR  = 2'd2
  } sabtc_act_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_UPDATE,
    S_CLEAR
  } sabtc_state_e;

endpackage

@@ hdl/sabtc_if.sv @@
// request and response channel interfaces
interface sabtc_req_if;
  import sabtc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SIDX_W-1:0]   set_index;
  logic [ADDR_W-1:0]   address;
  modport source (output valid, action, set_index, address, input ready);
  modport sink   (input valid, action, set_index, address, output ready);
endinterface

interface sabtc_rsp_if;
  import sabtc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way;
  logic                 displaced;
  modport source (output valid, hit, way, displaced, input ready);
  modport sink   (input valid, hit, way, displaced, output ready);
endinterface

@@ hdl/set_assoc_block_tag_clock_replace.sv @@
// top level of the set-associative block tag store with clock replacement
//
//  channel | dir | payload                        | transfer
//  --------+-----+--------------------------------+------------------------
//  req_i   | in  | action, set_index, address     | valid && ready
//  rsp_o   | out | hit, way, displaced            | valid && ready
//
// lookup and allocate: set row read from the tag ram and
// pointer ram, then match / clock pick and write-back in the update cycle
// clear-all: one tag ram row zeroed per cycle, clock pointers kept
// after reset an init sweep zeroes both rams; req not ready
// a full response register stalls the update (or last clear) cycle only;
// a new item is taken while an earlier response still waits
`include "assert_macros.svh"

module set_assoc_block_tag_clock_replace #(
  parameter int WAYS = sabtc_pkg::WAYS_DEF,
  parameter int SETS = sabtc_pkg::SETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sabtc_req_if.sink   req_i,
  sabtc_rsp_if.source rsp_o
);
  import sabtc_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W = WAYS * ENTRY_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  // control state
  sabtc_state_e     state_q, state_d;
  logic [SET_W-1:0] idx_q, idx_d;

  // captured request
  sabtc_act_e       act_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;

  // response register
  logic                 out_valid_q;
  logic                 out_hit_q, out_hit_d;
  logic [OUT_WAY_W-1:0] out_way_q, out_way_d;
  logic                 out_disp_q, out_disp_d;
  logic                 out_load;
  logic                 out_free;

  // ram ports
  logic             rd_en;
  logic             sweep;
  logic             tag_we, ptr_we;
  logic [SET_W-1:0] set_now;
  logic [SET_W-1:0] waddr;
  logic [ROW_W-1:0] rd_row, new_row, tag_wdata;
  logic [WAY_W-1:0] rd_ptr, ptr_wdata;

  // way selection
  logic             sel_hit;
  logic [WAY_W-1:0] sel_hit_way;
  logic [WAY_W-1:0] sel_fill_way;
  logic             sel_disp;
  logic [WAY_W+1:0] hit_way_ext, fill_way_ext;

  logic              in_ready;
  logic [TAG_W-1:0]  tag_now;
  logic [ADDR_W-1:0] addr_word;
  logic [SIDX_W-1:0] rem;
  logic [SET_W+SIDX_W-1:0] set_ext;

  // set index wraps modulo SETS: restoring subtract of shifted SETS
  always_comb begin
    rem = req_i.set_index;
    for (int k = SIDX_W - 1; k >= 0; k--) begin
      if (32'(rem) >= (32'(SETS) << k)) begin
        rem = rem - SIDX_W'(32'(SETS) << k);
      end
    end
    set_ext = {{SET_W{1'b0}}, rem};
    set_now = set_ext[SET_W-1:0];
  end

  assign addr_word = req_i.address & ADDR_WORD_MASK;
  assign tag_now   = addr_word[ADDR_W-1:2];

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = in_ready;

  // set row store: WAYS entries of {mark, word tag}
  sabtc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (waddr),
    .wdata_i (tag_wdata),
    .re_i    (rd_en),
    .raddr_i (set_now),
    .rdata_o (rd_row)
  );

  // clock pointer per set
  sabtc_ram #(
    .WIDTH (WAY_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (waddr),
    .wdata_i (ptr_wdata),
    .re_i    (rd_en),
    .raddr_i (set_now),
    .rdata_o (rd_ptr)
  );

  sabtc_way_sel #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_way_sel (
    .row_i       (rd_row),
    .ptr_i       (rd_ptr),
    .tag_i       (tag_q),
    .hit_o       (sel_hit),
    .hit_way_o   (sel_hit_way),
    .fill_way_o  (sel_fill_way),
    .displaced_o (sel_disp),
    .row_o       (new_row)
  );

  // way field is the low bits of the way number
  assign hit_way_ext  = {2'b00, sel_hit_way};
  assign fill_way_ext = {2'b00, sel_fill_way};

  // sweeps write zero rows by counter, updates write the request's set
  assign waddr     = sweep ? idx_q : set_q;
  assign tag_wdata = sweep ? '0 : new_row;
  assign ptr_wdata = sweep ? '0 : sel_fill_way;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      act_q <= sabtc_act_e'(req_i.action);
      tag_q <= tag_now;
      set_q <= set_now;
    end
    if (out_load) begin
      out_hit_q  <= out_hit_d;
      out_way_q  <= out_way_d;
      out_disp_q <= out_disp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    sweep      = 1'b0;
    tag_we     = 1'b0;
    ptr_we     = 1'b0;
    out_load   = 1'b0;
    out_hit_d  = 1'b0;
    out_way_d  = '0;
    out_disp_d = 1'b0;
    case (state_q)
      S_INIT: begin
        // zero tags and pointers after reset
        sweep  = 1'b1;
        tag_we = 1'b1;
        ptr_we = 1'b1;
        if (idx_q == LAST_SET) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (req_i.valid) begin
          rd_en = 1'b1;
          idx_d = '0;
          if (req_i.action == ACT_CLEAR) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (act_q)
            ACT_LOOKUP: begin
              if (tag_q != '0 && sel_hit) begin
                out_hit_d = 1'b1;
                out_way_d = hit_way_ext[OUT_WAY_W-1:0];
              end
            end
            ACT_ALLOC: begin
              // a zero word tag is never stored
              if (tag_q != '0) begin
                tag_we     = 1'b1;
                ptr_we     = sel_disp;
                out_way_d  = fill_way_ext[OUT_WAY_W-1:0];
                out_disp_d = sel_disp;
              end
            end
            default: begin
              // unused code: all-zero response, no state change
            end
          endcase
        end
      end
      S_CLEAR: begin
        // tags only, the clock pointers keep their values
        sweep  = 1'b1;
        tag_we = 1'b1;
        if (idx_q == LAST_SET) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.way       = out_way_q;
  assign rsp_o.displaced = out_disp_q;

  `SABTC_ASSERT(a_hit_not_displaced, out_valid_q |-> !(out_hit_q && out_disp_q), "hit and displaced both set")
  `SABTC_ASSERT(a_accept_next_state, (req_i.valid && in_ready) |=> (state_q == S_UPDATE || state_q == S_CLEAR), "accepted item did not start work")
  `SABTC_ASSERT(a_update_write_alloc, (state_q == S_UPDATE && tag_we) |-> (act_q == ACT_ALLOC && tag_q != '0), "tag write outside allocate")
  `SABTC_ASSERT(a_stall_holds_row, (state_q == S_UPDATE && !out_free) |=> $stable(rd_row), "set row changed during stall")
  `SABTC_ASSERT_ALWAYS(a_init_no_output, (state_q == S_INIT) |-> !out_valid_q, "response during init sweep")

endmodule

@@ hdl/sabtc_ram.sv @@
// simple dual port ram, one write and one registered read port
module sabtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/sabtc_way_sel.sv @@
// tag match, free way search and clock victim pick for one set row
module sabtc_way_sel #(
  parameter int WAYS  = 4,
  parameter int WAY_W = 2
) (
  input  logic [WAYS*sabtc_pkg::ENTRY_W-1:0] row_i,
  input  logic [WAY_W-1:0]                   ptr_i,
  input  logic [sabtc_pkg::TAG_W-1:0]        tag_i,
  output logic                               hit_o,
  output logic [WAY_W-1:0]                   hit_way_o,
  output logic [WAY_W-1:0]                   fill_way_o,
  output logic                               displaced_o,
  output logic [WAYS*sabtc_pkg::ENTRY_W-1:0] row_o
);
  import sabtc_pkg::*;

  localparam int DW = WAY_W + 1;

  logic [WAYS-1:0]     valid;
  logic [WAYS-1:0]     mark;
  logic [WAYS-1:0]     match;
  logic [DW-1:0]       gap [WAYS];
  logic [DW-1:0]       d_first;
  logic [DW:0]         vsum;
  logic [WAY_W-1:0]    victim;
  logic                free_any;
  logic [WAY_W-1:0]    free_way;

  always_comb begin
    // per-way status
    for (int w = 0; w < WAYS; w++) begin
      valid[w] = |row_i[w*ENTRY_W +: TAG_W];
      match[w] = valid[w] && (row_i[w*ENTRY_W +: TAG_W] == tag_i);
      mark[w]  = row_i[w*ENTRY_W + TAG_W];
      if (DW'(w) >= DW'(ptr_i)) begin
        gap[w] = DW'(w) - DW'(ptr_i);
      end else begin
        gap[w] = DW'(w) + DW'(WAYS) - DW'(ptr_i);
      end
    end

    // lowest matching way and lowest free way
    hit_o     = 1'b0;
    hit_way_o = '0;
    free_any  = 1'b0;
    free_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_o     = 1'b1;
        hit_way_o = WAY_W'(w);
      end
      if (!valid[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end

    // first marked way from the pointer; a full lap lands back on it
    d_first = DW'(WAYS);
    for (int w = 0; w < WAYS; w++) begin
      if (mark[w] && (gap[w] < d_first)) begin
        d_first = gap[w];
      end
    end
    vsum = (DW+1)'(ptr_i) + (DW+1)'(d_first);
    if (vsum >= (DW+1)'(WAYS)) begin
      vsum = vsum - (DW+1)'(WAYS);
    end
    victim = vsum[WAY_W-1:0];

    fill_way_o  = free_any ? free_way : victim;
    displaced_o = !free_any;

    // row to write back: on a displacement passed ways marked, new tag unmarked
    row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (!free_any && (gap[w] < d_first)) begin
        row_o[w*ENTRY_W + TAG_W] = 1'b1;
      end
      if (WAY_W'(w) == fill_way_o) begin
        row_o[w*ENTRY_W +: ENTRY_W] = {1'b0, tag_i};
      end
    end
  end

endmodule
